/* hw/rtl/bwl_pkg.sv */
// Shared types and constants for the Butterworth low-pass mask generator.
package bwl_pkg;

    // Field and register widths.
    localparam int COORD_W    = 10;
    localparam int CNT_W      = 11;
    localparam int CUT_W      = 16;
    localparam int ORD_W      = 4;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Datapath widths.
    localparam int OFS_W      = CNT_W;          // |doubled offset| <= 2046
    localparam int SQ_W       = 2 * OFS_W;      // one squared offset
    localparam int DIST_W     = SQ_W + 1;       // sum of two squares
    localparam int RATIO_SH   = 22;             // 2^16 (Q16.16) * 2^8 (Q4^2) / 4 (doubled^2)
    localparam int RNUM_W     = DIST_W + RATIO_SH;
    localparam int Q_W        = 32;             // Q16.16 word
    localparam int CUTSQ_W    = 2 * CUT_W;
    localparam int GDEN_W     = Q_W + 1;        // 1.0 plus power
    localparam int GNUM_W     = 32;             // numerator 2^31

    // Pipelined divider granularity: quotient bits resolved per stage.
    localparam int DIV_STEP_BITS = 2;

    // Largest number of power multiplications (twice the largest order).
    localparam int POW_STAGES = 2 * ((1 << ORD_W) - 1);

    // Fixed-point constants.
    localparam logic [Q_W-1:0]    Q16_ONE  = 32'h0001_0000;
    localparam logic [GNUM_W-1:0] GAIN_NUM = 32'h8000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT    = 8'd0,
        REG_COL_COUNT    = 8'd1,
        REG_CUTOFF_Q4    = 8'd2,
        REG_FILTER_ORDER = 8'd3
    } cfg_reg_t;

    // Register reset values.
    localparam logic [CNT_W-1:0] ROW_COUNT_RST    = 11'd512;
    localparam logic [CNT_W-1:0] COL_COUNT_RST    = 11'd512;
    localparam logic [CUT_W-1:0] CUTOFF_Q4_RST    = 16'd640;
    localparam logic [ORD_W-1:0] FILTER_ORDER_RST = 4'd2;

endpackage

/* hw/rtl/bwl_divider.sv */
// Pipelined restoring divider with overflow flag; STEP_BITS quotient bits per stage.
module bwl_divider #(
    parameter  int NUM_W     = 45,
    parameter  int DEN_W     = 32,
    parameter  int QUO_W     = 32,
    parameter  int STEP_BITS = 2,
    localparam int STAGES    = (QUO_W + STEP_BITS - 1) / STEP_BITS
) (
    input  logic              clk,
    input  logic [STAGES-1:0] en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUO_W-1:0]  quo,
    output logic              ovf
);

    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [QUO_W-1:0] low_reg [STAGES];
    logic [QUO_W-1:0] quo_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];
    logic             ovf_reg [STAGES];

    // Upper numerator bits form the first partial remainder; the quotient does not
    // fit its width when they already reach the divisor.
    logic [DEN_W-1:0] rem_first;
    logic             ovf_first;

    assign rem_first = DEN_W'(num[NUM_W-1:QUO_W]);
    assign ovf_first = (rem_first >= den);

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic [DEN_W-1:0] rem_in;
            logic [QUO_W-1:0] low_in;
            logic [QUO_W-1:0] quo_in;
            logic [DEN_W-1:0] den_in;
            logic             ovf_in;
            logic [DEN_W-1:0] rem_next;
            logic [QUO_W-1:0] low_next;
            logic [QUO_W-1:0] quo_next;

            if (s == 0)
            begin : g_head
                assign rem_in = rem_first;
                assign low_in = num[QUO_W-1:0];
                assign quo_in = '0;
                assign den_in = den;
                assign ovf_in = ovf_first;
            end
            else
            begin : g_body
                assign rem_in = rem_reg[s-1];
                assign low_in = low_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign den_in = den_reg[s-1];
                assign ovf_in = ovf_reg[s-1];
            end

            // Shift in one numerator bit, subtract when the divisor fits.
            always_comb
            begin
                logic [DEN_W:0] trial;
                trial    = '0;
                rem_next = rem_in;
                low_next = low_in;
                quo_next = quo_in;
                for (int j = 0; j < STEP_BITS; j++)
                begin
                    if (s * STEP_BITS + j < QUO_W)
                    begin
                        trial    = {rem_next, low_next[QUO_W-1]};
                        low_next = {low_next[QUO_W-2:0], 1'b0};
                        if (trial >= {1'b0, den_in})
                        begin
                            rem_next = DEN_W'(trial - {1'b0, den_in});
                            quo_next = {quo_next[QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = trial[DEN_W-1:0];
                            quo_next = {quo_next[QUO_W-2:0], 1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next;
                    low_reg[s] <= low_next;
                    quo_reg[s] <= quo_next;
                    den_reg[s] <= den_in;
                    ovf_reg[s] <= ovf_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[STAGES-1];
    assign ovf = ovf_reg[STAGES-1];

endmodule

/* hw/rtl/butterworth_lowpass_mask.sv */
// Top level of the Butterworth low-pass mask point generator.
//
//   Channel   Direction  Handshake              Beat contents
//   input     in         in_valid / in_ready    row_index, col_index
//   result    out        out_valid / out_ready  gain
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One point per cycle is accepted unless every stage holds a beat and the output is stalled.
// The depth is set by the chain of 30 power multipliers and the two pipelined
// dividers (16 stages for the ratio, 8 stages for the final gain).
// Reset clears the stage valid bits and loads the register defaults; no clearing pass.
// A stall only holds stages that have no empty stage below them, so bubbles close
// up and input keeps flowing while a finished beat waits at the output.
module butterworth_lowpass_mask #(
    parameter int MAX_DIM = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bwl_pkg::COORD_W-1:0]   row_index,
    input  logic [bwl_pkg::COORD_W-1:0]   col_index,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bwl_pkg::GAIN_W-1:0]    gain,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bwl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bwl_pkg::CFG_DATA_W-1:0] cfg_data
);

    import bwl_pkg::*;

    // Stage map of the pipeline.
    localparam int RDIV_ST  = (Q_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int GDIV_ST  = (GAIN_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int ST_FRONT = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_RDIV  = 2;
    localparam int ST_POW   = ST_RDIV + RDIV_ST;
    localparam int ST_GDIV  = ST_POW + POW_STAGES;
    localparam int ST_OUT   = ST_GDIV + GDIV_ST;
    localparam int NST      = ST_OUT + 1;

    // Largest usable count: the parameter, or the register's range if smaller.
    localparam int CNT_MAX_I = (1 << CNT_W) - 1;
    localparam int DIM_LIM_I = (MAX_DIM < CNT_MAX_I) ? MAX_DIM : CNT_MAX_I;
    localparam logic [CNT_W-1:0] DIM_LIMIT = DIM_LIM_I[CNT_W-1:0];

    // Centre in doubled coordinates: clamped count minus one.
    function automatic logic [CNT_W-1:0] center_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] fit;
        begin
            fit = cnt;
            if (cnt == '0)
            begin
                fit = CNT_W'(1);
            end
            else if (cnt > DIM_LIMIT)
            begin
                fit = DIM_LIMIT;
            end
            return fit - CNT_W'(1);
        end
    endfunction

    // Absolute doubled offset of a coordinate from the centre.
    function automatic logic [OFS_W-1:0] offset_of(input logic [COORD_W-1:0] crd,
                                                   input logic [CNT_W-1:0] ctr);
        logic [OFS_W:0] diff;
        begin
            diff = {1'b0, crd, 1'b0} - {1'b0, ctr};
            if (diff[OFS_W])
            begin
                diff = -diff;
            end
            return diff[OFS_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   row_count_reg;
    logic [CNT_W-1:0]   col_count_reg;
    logic [CUT_W-1:0]   cutoff_q4_reg;
    logic [ORD_W-1:0]   filter_order_reg;
    logic [CUTSQ_W-1:0] cut_sq_reg;
    logic [CUT_W-1:0]   cut_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_COUNT_RST;
            col_count_reg    <= COL_COUNT_RST;
            cutoff_q4_reg    <= CUTOFF_Q4_RST;
            filter_order_reg <= FILTER_ORDER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data[CNT_W-1:0];
                REG_COL_COUNT:    col_count_reg    <= cfg_data[CNT_W-1:0];
                REG_CUTOFF_Q4:    cutoff_q4_reg    <= cfg_data[CUT_W-1:0];
                REG_FILTER_ORDER: filter_order_reg <= cfg_data[ORD_W-1:0];
                default:          ;
            endcase
        end
    end

    // Squared cutoff is kept ready ahead of the ratio divider; a zero cutoff counts as one.
    assign cut_eff = (cutoff_q4_reg == '0) ? CUT_W'(1) : cutoff_q4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_sq_reg <= CUTSQ_W'(CUTOFF_Q4_RST) * CUTSQ_W'(CUTOFF_Q4_RST);
        end
        else
        begin
            cut_sq_reg <= CUTSQ_W'(cut_eff) * CUTSQ_W'(cut_eff);
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and load enables. A stage loads when it is empty or
    // the stage after it loads.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    assign en[NST-1] = !vld_reg[NST-1] || out_ready;

    genvar e;
    generate
        for (e = 0; e < NST - 1; e++)
        begin : g_en
            assign en[e] = !vld_reg[e] || en[e+1];
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (!en[i])
            begin
                vld_next[i] = vld_reg[i];
            end
            else if (i == 0)
            begin
                vld_next[i] = in_valid;
            end
            else
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[ST_FRONT];
    assign out_valid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Front stage: doubled offsets from the centre.
    // ------------------------------------------------------------------
    logic [OFS_W-1:0] dr_abs_reg;
    logic [OFS_W-1:0] dc_abs_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_FRONT])
        begin
            dr_abs_reg <= offset_of(row_index, center_of(row_count_reg));
            dc_abs_reg <= offset_of(col_index, center_of(col_count_reg));
        end
    end

    // ------------------------------------------------------------------
    // Square stage: four times the squared distance.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] dist_sq_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SQ])
        begin
            dist_sq_reg <= DIST_W'(SQ_W'(dr_abs_reg) * SQ_W'(dr_abs_reg))
                         + DIST_W'(SQ_W'(dc_abs_reg) * SQ_W'(dc_abs_reg));
        end
    end

    // ------------------------------------------------------------------
    // Ratio divider: D^2 / D0^2 in Q16.16, saturated.
    // ------------------------------------------------------------------
    logic [Q_W-1:0] ratio_quo;
    logic           ratio_ovf;
    logic [Q_W-1:0] ratio_sat;

    bwl_divider #(
        .NUM_W     (RNUM_W),
        .DEN_W     (CUTSQ_W),
        .QUO_W     (Q_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_ratio_div (
        .clk (clk),
        .en  (en[ST_POW-1:ST_RDIV]),
        .num ({dist_sq_reg, {RATIO_SH{1'b0}}}),
        .den (cut_sq_reg),
        .quo (ratio_quo),
        .ovf (ratio_ovf)
    );

    assign ratio_sat = ratio_ovf ? '1 : ratio_quo;

    // ------------------------------------------------------------------
    // Power chain: one saturating Q16.16 multiply per stage, skipped past 2n.
    // ------------------------------------------------------------------
    logic [Q_W-1:0]   power_reg [POW_STAGES];
    logic [Q_W-1:0]   ratio_reg [POW_STAGES];
    logic [ORD_W:0]   pow_steps;

    assign pow_steps = {filter_order_reg, 1'b0};

    genvar k;
    generate
        for (k = 0; k < POW_STAGES; k++)
        begin : g_pow
            localparam logic [ORD_W:0] STEP_K = (ORD_W + 1)'(k);
            logic [Q_W-1:0]   p_in;
            logic [Q_W-1:0]   r_in;
            logic [2*Q_W-1:0] prod;
            logic [Q_W-1:0]   p_next;

            if (k == 0)
            begin : g_head
                assign p_in = Q16_ONE;
                assign r_in = ratio_sat;
            end
            else
            begin : g_body
                assign p_in = power_reg[k-1];
                assign r_in = ratio_reg[k-1];
            end

            assign prod = (2 * Q_W)'(p_in) * (2 * Q_W)'(r_in);

            always_comb
            begin
                if (STEP_K < pow_steps)
                begin
                    p_next = (prod[2*Q_W-1:Q_W+16] != '0) ? '1 : prod[Q_W+15:16];
                end
                else
                begin
                    p_next = p_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[ST_POW + k])
                begin
                    power_reg[k] <= p_next;
                    ratio_reg[k] <= r_in;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Gain divider: 2^31 / (1.0 + power), never saturates.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] gain_quo;
    logic              gain_ovf;
    logic [GAIN_W-1:0] gain_reg;

    bwl_divider #(
        .NUM_W     (GNUM_W),
        .DEN_W     (GDEN_W),
        .QUO_W     (GAIN_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_gain_div (
        .clk (clk),
        .en  (en[ST_OUT-1:ST_GDIV]),
        .num (GAIN_NUM),
        .den (GDEN_W'(Q16_ONE) + GDEN_W'(power_reg[POW_STAGES-1])),
        .quo (gain_quo),
        .ovf (gain_ovf)
    );

    // Output register; an overflow cannot occur since the divisor exceeds 2^15.
    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            gain_reg <= gain_ovf ? '1 : gain_quo;
        end
    end

    assign gain = gain_reg;

endmodule

/* hw/rtl/bwl_checker.sv */
// Port-level checks for the Butterworth low-pass mask generator, bound to the top level.
module bwl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [bwl_pkg::COORD_W-1:0]   row_index,
    input logic [bwl_pkg::COORD_W-1:0]   col_index,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bwl_pkg::GAIN_W-1:0]    gain,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    import bwl_pkg::*;

    // A result beat that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gain))
        else $error("result beat dropped or changed while stalled");

    // The gain never exceeds 1.0 in Q1.15.
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain <= 16'd32768)
        else $error("gain above unity");

    // Input is refused only when every stage is full and the output is blocked.
    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused while the pipeline can move");

    // A point that is offered and not taken stays offered, unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(row_index) && $stable(col_index))
        else $error("input beat withdrawn or changed while refused");

    // Register writes are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind butterworth_lowpass_mask bwl_checker u_bwl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .row_index (row_index),
    .col_index (col_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gain      (gain),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
